[hdl/bezier_point_and_split_core_defines.svh]
// Assertion macros for the Bezier point and split core.
`ifndef BEZIER_POINT_AND_SPLIT_CORE_DEFINES_SVH
`define BEZIER_POINT_AND_SPLIT_CORE_DEFINES_SVH

// Same-cycle implication, checked on i_clk outside reset.
`define BZS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on i_clk outside reset.
`define BZS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/bzs_pkg.sv]
// Shared types and constants for the Bezier point and split core.
`timescale 1ns / 1ps
`default_nettype none

package bzs_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 64;
    localparam int PARAM_T_W   = 18;
    localparam int OUT_COORD_W = 32;
    localparam int TRI_N       = 10;

    localparam logic [CFG_INDEX_W-1:0] REG_DEGREE = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_CP0    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_CP1    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_CP2    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_CP3    = 3'd4;

    localparam logic CMD_EVAL  = 1'b0;
    localparam logic CMD_SPLIT = 1'b1;

    localparam logic [1:0] DEG_QUAD  = 2'd2;
    localparam logic [1:0] DEG_RESET = 2'd3;

    // Stage enables of one interpolation unit.
    typedef struct packed {
        logic mul;
        logic add;
    } t_lerp_en;

endpackage

`default_nettype wire

[hdl/bezier_point_and_split_core.sv]
// Top level of the Bezier point and split core: pipeline, configuration and serializer.
// Pipeline: a transfer in passes 7 pipeline stages plus the result stage before its first
//   result, then one result per cycle without output stall.
// Throughput: one evaluate per cycle without output stall; a subdivide holds the result
//   stage for 6 (quadratic) or 8 (cubic) output transfers, set by the single output channel.
// Reset: synchronous, active low; clears all valid bits and the result counter, and sets
//   the degree to cubic and all control points to zero.
`timescale 1ns / 1ps
`default_nettype none

module bezier_point_and_split_core #(
    parameter int COORD_WIDTH = 32,
    parameter int T_FRAC_BITS = 16
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    // configuration write port
    input  wire                                   i_cfg_we,
    input  wire [bzs_pkg::CFG_INDEX_W-1:0]        i_cfg_index,
    input  wire [bzs_pkg::CFG_DATA_W-1:0]         i_cfg_wdata,
    // input channel
    input  wire                                   i_valid,
    output logic                                  o_ready,
    input  wire                                   i_cmd,
    input  wire signed [bzs_pkg::PARAM_T_W-1:0]   i_param_t,
    // output channel
    output logic                                  o_valid,
    input  wire                                   i_ready,
    output logic signed [bzs_pkg::OUT_COORD_W-1:0] o_point_x,
    output logic signed [bzs_pkg::OUT_COORD_W-1:0] o_point_y,
    output logic                                  o_right_half,
    output logic [1:0]                            o_point_index,
    output logic                                  o_last_point
);

    `include "bezier_point_and_split_core_defines.svh"

    localparam int CW  = COORD_WIDTH;
    localparam int TF  = T_FRAC_BITS;
    localparam int TW  = TF + 1;
    localparam int OW  = bzs_pkg::OUT_COORD_W;
    localparam int PTW = bzs_pkg::PARAM_T_W;
    // wide enough for the raw parameter and for 1.0 plus a sign bit
    localparam int CLW = (TF + 2 > PTW) ? TF + 2 : PTW;
    localparam logic signed [CLW-1:0] T_ONE = CLW'(1) << TF;
    localparam int NST = 7;

    // ------------------------------------------------------------------
    // Configuration registers. Writes must come only while the core is idle,
    // which the block does not enforce; every stage reads them directly.
    // ------------------------------------------------------------------
    logic [1:0]                      r_degree;
    logic [bzs_pkg::CFG_DATA_W-1:0]  r_cp [4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_degree <= bzs_pkg::DEG_RESET;
            for (int i = 0; i < 4; i++) begin
                r_cp[i] <= '0;
            end
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                bzs_pkg::REG_DEGREE: r_degree <= i_cfg_wdata[1:0];
                bzs_pkg::REG_CP0:    r_cp[0]  <= i_cfg_wdata;
                bzs_pkg::REG_CP1:    r_cp[1]  <= i_cfg_wdata;
                bzs_pkg::REG_CP2:    r_cp[2]  <= i_cfg_wdata;
                bzs_pkg::REG_CP3:    r_cp[3]  <= i_cfg_wdata;
                default: ;  // drop writes past the register list
            endcase
        end
    end

    // Level 0 of the triangle: coordinate 0 is x, coordinate 1 is y.
    logic signed [CW-1:0] w_p [2][4];

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            w_p[0][i] = $signed(r_cp[i][32 +: CW]);
            w_p[1][i] = $signed(r_cp[i][0 +: CW]);
        end
    end

    logic       w_quad;
    logic [1:0] w_nm1;       // points per sub-curve minus one
    logic [2:0] w_last_cnt;  // counter value of the final subdivide result

    assign w_quad     = (r_degree == bzs_pkg::DEG_QUAD);
    assign w_nm1      = w_quad ? 2'd2 : 2'd3;
    assign w_last_cnt = w_quad ? 3'd5 : 3'd7;

    // ------------------------------------------------------------------
    // Stall handling: each stage loads when it is empty or its successor
    // loads, so bubbles collapse and nothing is dropped under backpressure.
    // Stage 0 clamps t; stages 1/2, 3/4 and 5/6 are the multiply and add
    // halves of triangle levels 1, 2 and 3.
    // ------------------------------------------------------------------
    logic [NST-1:0] r_v;
    logic [NST:0]   w_rdy;
    logic           w_ser_rdy;

    always_comb begin
        w_rdy[NST] = w_ser_rdy;
        for (int k = NST - 1; k >= 0; k--) begin
            w_rdy[k] = !r_v[k] || w_rdy[k+1];
        end
    end

    assign o_ready = w_rdy[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_rdy[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k < NST; k++) begin
                if (w_rdy[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // Clamp t to [0, 1.0].
    logic signed [CLW-1:0] w_t_ext;
    logic signed [CLW-1:0] w_t_clamp;

    always_comb begin
        w_t_ext = CLW'(i_param_t);
        if (w_t_ext < 0) begin
            w_t_clamp = '0;
        end else if (w_t_ext > T_ONE) begin
            w_t_clamp = T_ONE;
        end else begin
            w_t_clamp = w_t_ext;
        end
    end

    // t travels to the level 3 multiply; the command travels to the end.
    logic [TW-1:0]  r_t [5];
    logic [NST-1:0] r_cmd;

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r_t[0]   <= w_t_clamp[TW-1:0];
            r_cmd[0] <= i_cmd;
        end
        for (int k = 1; k < 5; k++) begin
            if (w_rdy[k]) begin
                r_t[k] <= r_t[k-1];
            end
        end
        for (int k = 1; k < NST; k++) begin
            if (w_rdy[k]) begin
                r_cmd[k] <= r_cmd[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Interpolation triangle. For a quadratic the level 1 lane 2 and the
    // levels above it see the stale fourth point, but no quadratic result
    // reads them.
    // ------------------------------------------------------------------
    logic signed [CW-1:0] w_l1 [2][3];   // valid in stage 2
    logic signed [CW-1:0] w_l2 [2][2];   // valid in stage 4
    logic signed [CW-1:0] w_l3 [2];      // valid in stage 6

    bzs_pkg::t_lerp_en w_en1, w_en2, w_en3;

    assign w_en1 = '{mul: w_rdy[1], add: w_rdy[2]};
    assign w_en2 = '{mul: w_rdy[3], add: w_rdy[4]};
    assign w_en3 = '{mul: w_rdy[5], add: w_rdy[6]};

    for (genvar c = 0; c < 2; c++) begin : g_coord
        for (genvar ln = 0; ln < 3; ln++) begin : g_l1
            bzs_lerp #(.CW(CW), .TF(TF)) u_lerp (
                .i_clk (i_clk),
                .i_en  (w_en1),
                .i_a   (w_p[c][ln]),
                .i_b   (w_p[c][ln+1]),
                .i_t   (r_t[0]),
                .o_q   (w_l1[c][ln])
            );
        end
        for (genvar ln = 0; ln < 2; ln++) begin : g_l2
            bzs_lerp #(.CW(CW), .TF(TF)) u_lerp (
                .i_clk (i_clk),
                .i_en  (w_en2),
                .i_a   (w_l1[c][ln]),
                .i_b   (w_l1[c][ln+1]),
                .i_t   (r_t[2]),
                .o_q   (w_l2[c][ln])
            );
        end
        bzs_lerp #(.CW(CW), .TF(TF)) u_l3 (
            .i_clk (i_clk),
            .i_en  (w_en3),
            .i_a   (w_l2[c][0]),
            .i_b   (w_l2[c][1]),
            .i_t   (r_t[4]),
            .o_q   (w_l3[c])
        );
    end

    // Carry the lower levels alongside so the result stage sees the whole triangle.
    logic signed [CW-1:0] r_l1_s3 [2][3];
    logic signed [CW-1:0] r_l1_s4 [2][3];
    logic signed [CW-1:0] r_l1_s5 [2][3];
    logic signed [CW-1:0] r_l1_s6 [2][3];
    logic signed [CW-1:0] r_l2_s5 [2][2];
    logic signed [CW-1:0] r_l2_s6 [2][2];

    always_ff @(posedge i_clk) begin
        if (w_rdy[3]) begin
            r_l1_s3 <= w_l1;
        end
        if (w_rdy[4]) begin
            r_l1_s4 <= r_l1_s3;
        end
        if (w_rdy[5]) begin
            r_l1_s5 <= r_l1_s4;
            r_l2_s5 <= w_l2;
        end
        if (w_rdy[6]) begin
            r_l1_s6 <= r_l1_s5;
            r_l2_s6 <= r_l2_s5;
        end
    end

    // ------------------------------------------------------------------
    // Result stage: hold one finished triangle and walk its results.
    // ------------------------------------------------------------------
    logic                 r_ser_valid;
    logic                 r_ser_cmd;
    logic [2:0]           r_cnt;
    logic signed [CW-1:0] r_ser_l1 [2][3];
    logic signed [CW-1:0] r_ser_l2 [2][2];
    logic signed [CW-1:0] r_ser_l3 [2];

    logic                 w_out_xfer;

    assign w_out_xfer = r_ser_valid && i_ready;
    assign w_ser_rdy  = !r_ser_valid || (i_ready && o_last_point);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ser_valid <= 1'b0;
            r_cnt       <= '0;
        end else begin
            if (w_ser_rdy) begin
                r_ser_valid <= r_v[NST-1];
            end
            if (w_out_xfer) begin
                // restart the walk after the final result, else advance
                r_cnt <= o_last_point ? 3'd0 : r_cnt + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ser_rdy) begin
            r_ser_cmd <= r_cmd[NST-1];
            r_ser_l1  <= r_l1_s6;
            r_ser_l2  <= r_l2_s6;
            r_ser_l3  <= w_l3;
        end
    end

    // Flattened triangle: level 0 at 0..3, level 1 at 4..6, level 2 at 7..8,
    // apex at 9.
    logic signed [CW-1:0] w_tri [2][bzs_pkg::TRI_N];

    always_comb begin
        for (int c = 0; c < 2; c++) begin
            for (int i = 0; i < 4; i++) begin
                w_tri[c][i] = w_p[c][i];
            end
            for (int i = 0; i < 3; i++) begin
                w_tri[c][4+i] = r_ser_l1[c][i];
            end
            for (int i = 0; i < 2; i++) begin
                w_tri[c][7+i] = r_ser_l2[c][i];
            end
            w_tri[c][9] = r_ser_l3[c];
        end
    end

    logic       w_right;
    logic [1:0] w_ri;      // index within the right sub-curve
    logic [1:0] w_lvl;
    logic [1:0] w_idx;
    logic [1:0] w_pidx;    // index of the point within its sub-curve
    logic [3:0] w_base;
    logic [3:0] w_pos;
    logic [2:0] w_ri_full;

    always_comb begin
        w_ri_full = r_cnt - {1'b0, w_nm1} - 3'd1;
        w_ri      = w_ri_full[1:0];
        w_right   = (r_ser_cmd == bzs_pkg::CMD_SPLIT) && (r_cnt > {1'b0, w_nm1});
        if (r_ser_cmd == bzs_pkg::CMD_EVAL) begin
            // apex of the triangle
            w_lvl  = w_nm1;
            w_idx  = 2'd0;
            w_pidx = 2'd0;
        end else if (!w_right) begin
            // left sub-curve: left column, top to bottom
            w_lvl  = r_cnt[1:0];
            w_idx  = 2'd0;
            w_pidx = r_cnt[1:0];
        end else begin
            // right sub-curve: right edge, apex down to the last point
            w_lvl  = w_nm1 - w_ri;
            w_idx  = w_ri;
            w_pidx = w_ri;
        end
        case (w_lvl)
            2'd0:    w_base = 4'd0;
            2'd1:    w_base = 4'd4;
            2'd2:    w_base = 4'd7;
            default: w_base = 4'd9;
        endcase
        w_pos = w_base + {2'b00, w_idx};
    end

    assign o_valid       = r_ser_valid;
    assign o_point_x     = OW'(w_tri[0][w_pos]);
    assign o_point_y     = OW'(w_tri[1][w_pos]);
    assign o_right_half  = w_right;
    assign o_point_index = w_pidx;
    assign o_last_point  = (r_ser_cmd == bzs_pkg::CMD_EVAL) || (r_cnt == w_last_cnt);

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `BZS_ASSERT_NOW(a_eval_single, (o_valid && r_ser_cmd == bzs_pkg::CMD_EVAL), o_last_point, "evaluate result not marked last")
    `BZS_ASSERT_NOW(a_cnt_range, r_ser_valid, (r_cnt <= w_last_cnt), "result counter past final subdivide result")
    `BZS_ASSERT_NEXT(a_stall_hold, (o_valid && !i_ready), (o_valid && $stable(r_cnt)), "result walk moved during output stall")
    `BZS_ASSERT_NEXT(a_cnt_restart, (o_valid && i_ready && o_last_point), (r_cnt == 3'd0), "result counter not restarted after final result")

endmodule

`default_nettype wire

[hdl/bzs_lerp.sv]
// Two-stage fixed-point linear interpolation a + floor((b - a) * t / 2^TF).
`timescale 1ns / 1ps
`default_nettype none

module bzs_lerp #(
    parameter int CW = 32,
    parameter int TF = 16
) (
    input  wire                  i_clk,
    input  bzs_pkg::t_lerp_en    i_en,
    input  wire signed [CW-1:0]  i_a,
    input  wire signed [CW-1:0]  i_b,
    input  wire        [TF:0]    i_t,
    output logic signed [CW-1:0] o_q
);

    localparam int PW = CW + TF + 2;

    logic signed [CW:0]   w_diff;
    logic signed [PW-1:0] w_prod;
    logic signed [PW-1:0] w_shift;
    logic signed [CW:0]   w_sum;
    logic signed [PW-1:0] r_prod;
    logic signed [CW-1:0] r_a;
    logic signed [CW-1:0] r_q;

    always_comb begin
        w_diff  = (CW+1)'(i_b) - (CW+1)'(i_a);
        w_prod  = w_diff * $signed({1'b0, i_t});
        // floor division: arithmetic shift
        w_shift = r_prod >>> TF;
        w_sum   = (CW+1)'(r_a) + $signed(w_shift[CW:0]);
    end

    always_ff @(posedge i_clk) begin
        if (i_en.mul) begin
            r_prod <= w_prod;
            r_a    <= i_a;
        end
        if (i_en.add) begin
            r_q <= w_sum[CW-1:0];
        end
    end

    assign o_q = r_q;

endmodule

`default_nettype wire
